// File: hw/rtl/reqrt_pkg.sv
package reqrt_pkg;

   // queue geometry
   localparam int QUEUE_DEPTH   = 8;
   localparam int ADDRESS_BYTES = 5;
   localparam int PAYLOAD_WORDS = 4;

   // field widths
   localparam int BYTE_W      = 8;
   localparam int MODE_W      = 3;
   localparam int ADDR_W      = 40;
   localparam int LEN_W       = 6;
   localparam int WORD_W      = 64;
   localparam int SLOT_W      = 2;
   localparam int KIND_W      = 2;
   localparam int RTYPE_W     = 2;
   localparam int WIDX_W      = 2;
   localparam int COUNT_W     = 4;
   localparam int TICKS_W     = 16;
   localparam int CSR_INDEX_W = 2;

   localparam int MAX_LEN       = PAYLOAD_WORDS * BYTE_W;
   localparam int PAYLOAD_BYTES = PAYLOAD_WORDS * BYTE_W;

   localparam logic [ADDR_W-1:0] ADDR_MASK =
      ADDR_W'((64'd1 << (ADDRESS_BYTES * BYTE_W)) - 64'd1);

   localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd100;

   // input modes
   localparam logic [MODE_W-1:0] MODE_STAGE  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_DATA   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ACKED  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_FAILED = 3'd3;
   localparam logic [MODE_W-1:0] MODE_TICK   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_POP    = 3'd5;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WORD   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

   // record types
   localparam logic [RTYPE_W-1:0] REC_DATA        = 2'd0;
   localparam logic [RTYPE_W-1:0] REC_ACK_OK      = 2'd1;
   localparam logic [RTYPE_W-1:0] REC_ACK_TIMEOUT = 2'd2;
   localparam logic [RTYPE_W-1:0] REC_RSP_TIMEOUT = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LISTEN  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT = 2'd1;

   typedef struct packed {
      logic [RTYPE_W-1:0]                   rtype;
      logic [ADDR_W-1:0]                    addr;
      logic [LEN_W-1:0]                     len;
      logic [PAYLOAD_WORDS-1:0][WORD_W-1:0] words;
   } qrec_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

   typedef struct packed {
      logic arm;
      logic disarm;
      logic tick;
   } timer_ctl_type;

   typedef struct packed {
      logic armed;
      logic zero;
   } timer_stat_type;

endpackage

// File: hw/rtl/radio_event_queue_with_response_timeout.sv
// Radio event queue with response timeout.
//
// req channel: one event per transaction. tuser carries the mode (stage word,
// data received, tx acked, tx failed, tick, pop); tdata the packet fields.
// rsp channel: results, registered. Every event other than a pop gives one status
// result in the cycle after acceptance; a pop of an empty queue gives one empty result,
// a pop of a non-empty queue gives PAYLOAD_WORDS record words, tlast on the final one.
// csr channel: register writes, always ready; write only while no event is in flight.
//
// Throughput: one event per cycle for all modes but pop while rsp_tready is high; a
// pop of a non-empty queue holds req_tready low while the word sequencer drains the
// popped record. Records sit in a chain of QUEUE_DEPTH cells that shift toward
// the head on a pop; a push loads the cell at the fill count.
// Reset: queue empty, timer disarmed, staging words zero, listen address zero,
// timeout 100 ticks.
// Stall: a result waits in the output register while rsp_tready is low and
// req_tready drops until it is taken.
module radio_event_queue_with_response_timeout import reqrt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   // req
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [111:0]  req_tdata,  // peer_address[39:0], payload_length[45:40],
                                     // payload_word[109:46], word_slot[111:110]
   input  logic [MODE_W-1:0] req_tuser,  // mode[2:0]
   // rsp
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [127:0]  rsp_tdata,  // accepted[0], listen_request[1], timeout_fired[2],
                                     // record_type[4:3], record_address[44:5],
                                     // record_length[50:45], record_word[114:51],
                                     // record_word_index[116:115], queued_count[120:117]
   output logic [KIND_W-1:0] rsp_tuser,  // result_kind[1:0]
   output logic          rsp_tlast,
   // csr
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]      csr_data
);

   localparam int RSP_DATA_W = 128;

   // configuration
   logic [ADDR_W-1:0]  listen_ff;
   logic [TICKS_W-1:0] ticks_ff;

   // queue control
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [PAYLOAD_WORDS-1:0][WORD_W-1:0] staging_ff, staging_in;

   // pop sequencer
   logic               pop_active_ff, pop_active_in;
   logic [WIDX_W-1:0]  pop_idx_ff, pop_idx_in;
   qrec_type           pop_rec_ff, pop_rec_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [KIND_W-1:0]     rsp_kind_ff, rsp_kind_in;
   logic                  rsp_last_ff, rsp_last_in;

   // decoded request
   logic [MODE_W-1:0] mode;
   logic [ADDR_W-1:0] peer;
   logic [LEN_W-1:0]  plen, sat_len;
   logic [WORD_W-1:0] pword;
   logic [SLOT_W-1:0] pslot;

   logic acc_in, free, full, fire_now, push_want, push, pop_go, pop_empty;
   qrec_type       new_rec;
   qrec_type       recs [QUEUE_DEPTH];
   cell_ctl_type   cell_ctl [QUEUE_DEPTH];
   timer_ctl_type  timer_ctl;
   timer_stat_type timer_stat;
   logic [PAYLOAD_BYTES-1:0][BYTE_W-1:0] masked_bytes;

   function automatic logic [RSP_DATA_W-1:0] pack_rsp(
      input logic               acc,
      input logic               lis,
      input logic               fired,
      input logic [RTYPE_W-1:0] rtype,
      input logic [ADDR_W-1:0]  addr,
      input logic [LEN_W-1:0]   len,
      input logic [WORD_W-1:0]  word,
      input logic [WIDX_W-1:0]  idx,
      input logic [COUNT_W-1:0] count
   );
      pack_rsp = RSP_DATA_W'({count, idx, word, len, addr, rtype, fired, lis, acc});
   endfunction

   assign mode  = req_tuser;
   assign peer  = req_tdata[39:0] & ADDR_MASK;
   assign plen  = req_tdata[45:40];
   assign pword = req_tdata[109:46];
   assign pslot = req_tdata[111:110];

   assign free       = !rsp_valid_ff || rsp_tready;
   assign req_tready = free && !pop_active_ff;
   assign acc_in     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign full      = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign fire_now  = (mode == MODE_TICK) && timer_stat.armed && timer_stat.zero;
   assign sat_len   = (plen > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : plen;
   assign pop_go    = acc_in && (mode == MODE_POP) && (count_ff != '0);
   assign pop_empty = (mode == MODE_POP) && (count_ff == '0);

   always_comb begin
      unique case (mode)
         MODE_DATA, MODE_ACKED, MODE_FAILED: push_want = 1'b1;
         MODE_TICK:                          push_want = fire_now;
         default:                            push_want = 1'b0;
      endcase
   end

   assign push = acc_in && push_want && !full;

   // bytes at or past the record length read as zero
   always_comb begin
      for (int b = 0; b < PAYLOAD_BYTES; b++) begin
         masked_bytes[b] = (LEN_W'(b) < sat_len) ?
                           staging_ff[b / BYTE_W][(b % BYTE_W) * BYTE_W +: BYTE_W] : '0;
      end
   end

   always_comb begin
      new_rec = '0;
      unique case (mode)
         MODE_DATA: begin
            new_rec.rtype = REC_DATA;
            new_rec.addr  = peer;
            new_rec.len   = sat_len;
            new_rec.words = masked_bytes;
         end
         MODE_ACKED: begin
            new_rec.rtype = REC_ACK_OK;
            new_rec.addr  = peer;
         end
         MODE_FAILED: begin
            new_rec.rtype = REC_ACK_TIMEOUT;
            new_rec.addr  = peer;
         end
         default: begin
            new_rec.rtype = REC_RSP_TIMEOUT;
            new_rec.addr  = listen_ff & ADDR_MASK;
         end
      endcase
   end

   // chain of record cells, cell 0 is the head
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      qrec_type up_rec;
      if (i == QUEUE_DEPTH - 1) begin : g_end
         assign up_rec = '0;
      end else begin : g_mid
         assign up_rec = recs[i+1];
      end
      assign cell_ctl[i].shift = pop_go;
      assign cell_ctl[i].load  = push && (count_ff == COUNT_W'(i));
      reqrt_cell u_cell (
         .clock   (clock),
         .ctl     (cell_ctl[i]),
         .up_rec  (up_rec),
         .new_rec (new_rec),
         .rec     (recs[i])
      );
   end

   assign timer_ctl.arm    = push && (mode == MODE_ACKED);
   assign timer_ctl.disarm = push && (mode == MODE_DATA);
   assign timer_ctl.tick   = acc_in && (mode == MODE_TICK);

   reqrt_timer u_timer (
      .clock      (clock),
      .reset      (reset),
      .ctl        (timer_ctl),
      .load_ticks (ticks_ff),
      .stat       (timer_stat)
   );

   always_comb begin
      count_in = count_ff;
      if (push) begin
         count_in = count_ff + 1'b1;
      end else if (pop_go) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      staging_in = staging_ff;
      if (acc_in && (mode == MODE_STAGE) &&
          ({1'b0, pslot} < (SLOT_W+1)'(PAYLOAD_WORDS))) begin
         staging_in[pslot] = pword;
      end
   end

   // output register and word sequencer
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_last_in   = rsp_last_ff;
      pop_active_in = pop_active_ff;
      pop_idx_in    = pop_idx_ff;
      pop_rec_in    = pop_go ? recs[0] : pop_rec_ff;
      priority if (acc_in) begin
         rsp_valid_in = 1'b1;
         if (pop_go) begin
            rsp_kind_in   = KIND_WORD;
            rsp_data_in   = pack_rsp(1'b0, 1'b0, 1'b0, recs[0].rtype, recs[0].addr,
                                     recs[0].len, recs[0].words[0], '0, count_in);
            rsp_last_in   = (PAYLOAD_WORDS == 1);
            pop_active_in = (PAYLOAD_WORDS > 1);
            pop_idx_in    = WIDX_W'(1);
         end else if (pop_empty) begin
            rsp_kind_in = KIND_EMPTY;
            rsp_data_in = pack_rsp(1'b0, 1'b0, 1'b0, '0, '0, '0, '0, '0, count_in);
            rsp_last_in = 1'b1;
         end else begin
            rsp_kind_in = KIND_STATUS;
            rsp_data_in = pack_rsp(push, push && (mode == MODE_ACKED),
                                   acc_in && fire_now, '0, '0, '0, '0, '0, count_in);
            rsp_last_in = 1'b1;
         end
      end else if (pop_active_ff && free) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = KIND_WORD;
         rsp_data_in   = pack_rsp(1'b0, 1'b0, 1'b0, pop_rec_ff.rtype, pop_rec_ff.addr,
                                  pop_rec_ff.len, pop_rec_ff.words[pop_idx_ff],
                                  pop_idx_ff, count_ff);
         rsp_last_in   = (pop_idx_ff == WIDX_W'(PAYLOAD_WORDS - 1));
         pop_active_in = (pop_idx_ff != WIDX_W'(PAYLOAD_WORDS - 1));
         pop_idx_in    = pop_idx_ff + 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         listen_ff     <= '0;
         ticks_ff      <= TICKS_RESET;
         count_ff      <= '0;
         staging_ff    <= '0;
         pop_active_ff <= 1'b0;
         pop_idx_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && (csr_index == CSR_LISTEN)) begin
            listen_ff <= csr_data;
         end
         if (csr_valid && (csr_index == CSR_TIMEOUT)) begin
            ticks_ff <= csr_data[TICKS_W-1:0];
         end
         count_ff      <= count_in;
         staging_ff    <= staging_in;
         pop_active_ff <= pop_active_in;
         pop_idx_ff    <= pop_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pop_rec_ff  <= pop_rec_in;
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // a pop of a non-empty queue keeps the sequencer busy for the remaining words
   a_pop_busy: assert property (@(posedge clock) disable iff (reset)
      pop_go |=> pop_active_ff)
      else $error("pop sequencer not started");

   // fill count moves by at most one record per cycle and never passes the depth
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff <= COUNT_W'(QUEUE_DEPTH)) &&
         ((count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + 1'b1) ||
          (count_ff == $past(count_ff) - 1'b1)))
      else $error("queue count out of step");

   // an expiring tick leaves the timer disarmed
   a_timer_expire: assert property (@(posedge clock) disable iff (reset)
      (acc_in && fire_now) |=> !timer_stat.armed)
      else $error("timer still armed after expiry");

endmodule

// File: hw/rtl/reqrt_cell.sv
module reqrt_cell import reqrt_pkg::*; (
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  qrec_type     up_rec,
   input  qrec_type     new_rec,
   output qrec_type     rec
);

   qrec_type rec_ff, rec_in;

   // shift toward the head on a pop, else take a new record when this is the tail slot
   always_comb begin
      rec_in = rec_ff;
      if (ctl.shift) begin
         rec_in = up_rec;
      end else if (ctl.load) begin
         rec_in = new_rec;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec = rec_ff;

endmodule

// File: hw/rtl/reqrt_timer.sv
module reqrt_timer import reqrt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  timer_ctl_type      ctl,
   input  logic [TICKS_W-1:0] load_ticks,
   output timer_stat_type     stat
);

   logic               armed_ff, armed_in;
   logic [TICKS_W-1:0] remaining_ff, remaining_in;

   always_comb begin
      armed_in     = armed_ff;
      remaining_in = remaining_ff;
      if (ctl.arm) begin
         armed_in     = 1'b1;
         remaining_in = load_ticks;
      end else if (ctl.disarm) begin
         armed_in = 1'b0;
      end else if (ctl.tick && armed_ff) begin
         if (remaining_ff == '0) begin
            armed_in = 1'b0;  // expired
         end else begin
            remaining_in = remaining_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff     <= 1'b0;
         remaining_ff <= '0;
      end else begin
         armed_ff     <= armed_in;
         remaining_ff <= remaining_in;
      end
   end

   assign stat.armed = armed_ff;
   assign stat.zero  = (remaining_ff == '0);

endmodule
